// ----- src/cdp_pkg.sv -----
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types, constants and the register write table of the divider
// programmer.
// ----------------------------------------------------------------------------
package cdp_pkg;

	localparam int FRAC_BITS_DEF = 20;
	localparam int QUEUE_DEPTH   = 2;
	localparam int NUM_WRITES    = 31;
	localparam int IDX_W         = 5;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_XTAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOADCAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT0    = 3'd4;

	localparam logic [25:0] XTAL_RST    = 26'd25000000;
	localparam logic [31:0] CORR_RST    = 32'd1073374730;
	localparam logic [31:0] FLOOR_RST   = 32'd600000000;
	localparam logic [7:0]  LOADCAP_RST = 8'd2;
	localparam logic [7:0]  OUT0_RST    = 8'h4F;

	localparam logic [20:0] FRAC_DEN    = 21'd1048575;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WRITES - 1);
	localparam logic [7:0]  FINAL_ADDR  = 8'd177;

	typedef enum logic [3:0] {
		F_IDLE, F_DIV1, F_ADJ1, F_MUL1, F_ADJ2, F_MUL2, F_DIV2, F_FIN1, F_FIN2, F_PUSH
	} front_state_t;

	typedef struct packed {
		logic [23:0] p1;
		logic [19:0] p2;
		logic [23:0] q1;
	} setup_t;

	typedef struct packed {
		logic [7:0] out0;
		logic [7:0] load_cap;
	} bytes_t;

	// Address in the high byte, value in the low byte.
	function automatic logic [15:0] write_entry(input logic [IDX_W-1:0] idx,
	                                            input setup_t s, input bytes_t c);
		logic [15:0] e;
		case (idx)
			5'd0:  e = {8'd3, 8'hFF};
			5'd1:  e = {8'd16, 8'h80};
			5'd2:  e = {8'd17, 8'h80};
			5'd3:  e = {8'd18, 8'h80};
			5'd4:  e = {8'd19, 8'h80};
			5'd5:  e = {8'd20, 8'h80};
			5'd6:  e = {8'd21, 8'h80};
			5'd7:  e = {8'd22, 8'h80};
			5'd8:  e = {8'd23, 8'h80};
			5'd9:  e = {8'd15, 8'h00};
			5'd10: e = {8'd24, 8'h00};
			5'd11: e = {8'd16, c.out0};
			5'd12: e = {8'd183, c.load_cap};
			5'd13: e = {8'd3, 8'hFE};
			5'd14: e = {8'd26, 8'hFF};
			5'd15: e = {8'd27, 8'hFF};
			5'd16: e = {8'd28, s.p1[23:16]};
			5'd17: e = {8'd29, s.p1[15:8]};
			5'd18: e = {8'd30, s.p1[7:0]};
			5'd19: e = {8'd31, 4'hF, s.p2[19:16]};
			5'd20: e = {8'd32, s.p2[15:8]};
			5'd21: e = {8'd33, s.p2[7:0]};
			5'd22: e = {8'd42, 8'h00};
			5'd23: e = {8'd43, 8'h01};
			5'd24: e = {8'd44, s.q1[23:16]};
			5'd25: e = {8'd45, s.q1[15:8]};
			5'd26: e = {8'd46, s.q1[7:0]};
			5'd27: e = {8'd47, 8'h00};
			5'd28: e = {8'd48, 8'h00};
			5'd29: e = {8'd49, 8'h00};
			5'd30: e = {FINAL_ADDR, 8'h20};
			default: e = 16'h0000;
		endcase
		return e;
	endfunction

endpackage

// ----- src/cdp_front.sv -----
// ----------------------------------------------------------------------------
// cdp_front
// Accepts frequency requests and computes the divider words with two
// iterative dividers (two quotient bits per cycle) and registered multipliers.
// ----------------------------------------------------------------------------
module cdp_front #(
	parameter int FRAC_BITS = cdp_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,
	input  logic [25:0]        xtal_hz,
	input  logic [31:0]        correction_q30,
	input  logic [31:0]        vco_floor_hz,
	input  logic               q_full,
	output logic               q_push,
	output cdp_pkg::setup_t    q_data
);

	localparam int QBE      = ((34 + FRAC_BITS + 1) / 2) * 2;
	localparam int HI       = QBE - FRAC_BITS;
	localparam int D2_STEPS = QBE / 2;
	localparam int CW       = $clog2(D2_STEPS + 1);

	cdp_pkg::front_state_t state_q, state_d;

	logic              in_full_q;
	logic [31:0]       in_data_q;
	logic              take;
	logic [31:0]       fout_q;
	logic [31:0]       d1_rem_q, d1_num_q, d1_rem_d, d1_num_d;
	logic [55:0]       d2_rem_q, d2_rem_d;
	logic [QBE-1:0]    d2_num_q, d2_num_d;
	logic [CW-1:0]     cnt_q;
	logic [31:0]       a_q, prod0_q, fvco_q, a_adj;
	logic [63:0]       prod;
	logic [55:0]       den;
	logic [19:0]       b_q;
	logic [16:0]       ip_q;
	logic [FRAC_BITS-1:0] f_sel;
	logic [16:0]       ip_sel;
	logic [FRAC_BITS+19:0] fb;
	logic [26:0]       x;
	logic [20:0]       r;
	logic [7:0]        qv;
	cdp_pkg::setup_t   res_q, res_d;

	assign s_tready = !in_full_q;
	assign den = {xtal_hz, 30'd0};
	assign prod = 64'(fvco_q) * 64'(correction_q30);

	always_comb begin
		logic [32:0] t1;
		logic [56:0] t2;
		d1_rem_d = d1_rem_q;
		d1_num_d = d1_num_q;
		d2_rem_d = d2_rem_q;
		d2_num_d = d2_num_q;
		for (int k = 0; k < 2; k++) begin
			t1 = {d1_rem_d, d1_num_d[31]};
			d1_num_d = {d1_num_d[30:0], 1'b0};
			if (t1 >= {1'b0, fout_q}) begin
				d1_rem_d = 32'(t1 - {1'b0, fout_q});
				d1_num_d[0] = 1'b1;
			end else begin
				d1_rem_d = t1[31:0];
			end
			t2 = {d2_rem_d, d2_num_d[QBE-1]};
			d2_num_d = {d2_num_d[QBE-2:0], 1'b0};
			if (t2 >= {1'b0, den}) begin
				d2_rem_d = 56'(t2 - {1'b0, den});
				d2_num_d[0] = 1'b1;
			end else begin
				d2_rem_d = t2[55:0];
			end
		end
	end

	always_comb begin
		if (d1_num_q < 32'd6) begin
			a_adj = 32'd6;
		end else if (d1_num_q[0]) begin
			a_adj = d1_num_q + 32'd1;
		end else begin
			a_adj = d1_num_q;
		end
	end

	always_comb begin
		if (xtal_hz == 26'd0) begin
			f_sel  = '0;
			ip_sel = '1;
		end else begin
			f_sel  = d2_num_q[FRAC_BITS-1:0];
			ip_sel = d2_num_q[FRAC_BITS+16:FRAC_BITS];
		end
		fb = (FRAC_BITS+20)'({f_sel, 20'd0} - (FRAC_BITS+20)'(f_sel));
	end

	always_comb begin
		x = {b_q, 7'd0};
		r = {1'b0, x[19:0]} + 21'(x[26:20]);
		qv = {1'b0, x[26:20]};
		if (r >= cdp_pkg::FRAC_DEN) begin
			r  = r - cdp_pkg::FRAC_DEN;
			qv = qv + 8'd1;
		end
		res_d.p1 = ({ip_q, 7'd0} + 24'(qv) - 24'd512) | 24'h100000;
		res_d.p2 = r[19:0];
		res_d.q1 = {a_q[16:0], 7'd0} - 24'd512;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cdp_pkg::F_IDLE: if (in_full_q) state_d = cdp_pkg::F_DIV1;
			cdp_pkg::F_DIV1: if (cnt_q == CW'(15)) state_d = cdp_pkg::F_ADJ1;
			cdp_pkg::F_ADJ1: state_d = cdp_pkg::F_MUL1;
			cdp_pkg::F_MUL1: state_d = cdp_pkg::F_ADJ2;
			cdp_pkg::F_ADJ2: state_d = cdp_pkg::F_MUL2;
			cdp_pkg::F_MUL2: state_d = cdp_pkg::F_DIV2;
			cdp_pkg::F_DIV2: if (cnt_q == CW'(D2_STEPS - 1)) state_d = cdp_pkg::F_FIN1;
			cdp_pkg::F_FIN1: state_d = cdp_pkg::F_FIN2;
			cdp_pkg::F_FIN2: state_d = cdp_pkg::F_PUSH;
			cdp_pkg::F_PUSH: if (!q_full) state_d = cdp_pkg::F_IDLE;
			default: state_d = cdp_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		take   = (state_q == cdp_pkg::F_IDLE) && in_full_q;
		q_push = (state_q == cdp_pkg::F_PUSH) && !q_full;
		q_data = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cdp_pkg::F_IDLE;
			in_full_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (s_tvalid && s_tready) begin
				in_full_q <= 1'b1;
			end else if (take) begin
				in_full_q <= 1'b0;
			end
			if (state_q == cdp_pkg::F_DIV1 || state_q == cdp_pkg::F_DIV2) begin
				cnt_q <= (state_d != state_q) ? '0 : cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_data_q <= s_tdata;
		end
		case (state_q)
			cdp_pkg::F_IDLE: begin
				fout_q   <= in_data_q;
				d1_num_q <= vco_floor_hz;
				d1_rem_q <= '0;
			end
			cdp_pkg::F_DIV1: begin
				d1_num_q <= d1_num_d;
				d1_rem_q <= d1_rem_d;
			end
			cdp_pkg::F_ADJ1: a_q <= a_adj;
			cdp_pkg::F_MUL1: prod0_q <= 32'(64'(a_q) * 64'(fout_q));
			cdp_pkg::F_ADJ2: begin
				if (prod0_q < vco_floor_hz) begin
					a_q    <= a_q + 32'd2;
					fvco_q <= prod0_q + {fout_q[30:0], 1'b0};
				end else begin
					fvco_q <= prod0_q;
				end
			end
			cdp_pkg::F_MUL2: begin
				d2_rem_q <= 56'(prod >> HI);
				d2_num_q <= {prod[HI-1:0], {FRAC_BITS{1'b0}}};
			end
			cdp_pkg::F_DIV2: begin
				d2_num_q <= d2_num_d;
				d2_rem_q <= d2_rem_d;
			end
			cdp_pkg::F_FIN1: begin
				b_q  <= fb[FRAC_BITS+19:FRAC_BITS];
				ip_q <= ip_sel;
			end
			cdp_pkg::F_FIN2: res_q <= res_d;
			default: ;
		endcase
	end

endmodule

// ----- src/cdp_queue.sv -----
// ----------------------------------------------------------------------------
// cdp_queue
// Short queue of computed divider word sets between front and back.
// ----------------------------------------------------------------------------
module cdp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cdp_pkg::setup_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output cdp_pkg::setup_t rdata
);

	localparam int AW = (cdp_pkg::QUEUE_DEPTH > 1) ? $clog2(cdp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(cdp_pkg::QUEUE_DEPTH + 1);

	cdp_pkg::setup_t mem_q [cdp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = (cnt_q == CNTW'(cdp_pkg::QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(cdp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(cdp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ----- src/cdp_back.sv -----
// ----------------------------------------------------------------------------
// cdp_back
// Sequencer that plays out the 31 register writes of one word set through
// an output register.
// ----------------------------------------------------------------------------
module cdp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  cdp_pkg::setup_t q_data,
	output logic            q_pop,
	input  cdp_pkg::bytes_t bytes,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic            m_tlast
);

	logic                        busy_q;
	logic [cdp_pkg::IDX_W-1:0]   idx_q;
	cdp_pkg::setup_t             cur_q;
	logic                        out_valid_q;
	logic [15:0]                 out_data_q;
	logic                        out_last_q;
	logic                        load;
	logic [15:0]                 entry;

	assign load  = busy_q && (!out_valid_q || m_tready);
	assign q_pop = !busy_q && q_valid;
	assign entry = cdp_pkg::write_entry(idx_q, cur_q, bytes);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				if (idx_q == cdp_pkg::LAST_IDX) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + cdp_pkg::IDX_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (load) begin
			out_data_q <= {entry[7:0], entry[15:8]};
			out_last_q <= (idx_q == cdp_pkg::LAST_IDX);
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= cdp_pkg::LAST_IDX) else $error("write index out of range");
	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> out_data_q[7:0] == cdp_pkg::FINAL_ADDR)
		else $error("last write at wrong address");
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idx_q == cdp_pkg::LAST_IDX) |=> !busy_q) else $error("run did not end");

endmodule

// ----- src/clock_synth_divider_programmer.sv -----
// ----------------------------------------------------------------------------
// clock_synth_divider_programmer
// Turns a requested output frequency into the register write sequence that
// sets up the feedback and output dividers of a clock synthesizer.
//
// Usage: s_tdata carries fout_hz; each accepted transaction yields 31
// transactions on the master side, m_tdata = {reg_value, reg_addr} and
// m_tlast high on the 31st. Configuration is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle.
// The first write follows the output divider and the feedback ratio
// divider, both producing two quotient bits per cycle. The 31 writes of
// one request play out while the next request is computed, and two
// computed sets wait in the queue between the stages.
// Reset clears all control state and loads the register defaults.
// A stalled receiver holds the current write; computing goes on until the
// queue is full, then the input stops once its input register holds a request.
// ----------------------------------------------------------------------------
module clock_synth_divider_programmer #(
	parameter int FRAC_BITS = cdp_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // fout_hz
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // {reg_value, reg_addr}
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [cdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_wdata
);

	logic [25:0]     xtal_q;
	logic [31:0]     corr_q;
	logic [31:0]     floor_q;
	cdp_pkg::bytes_t bytes_q;

	logic            q_full, q_push, q_valid, q_pop;
	cdp_pkg::setup_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q           <= cdp_pkg::XTAL_RST;
			corr_q           <= cdp_pkg::CORR_RST;
			floor_q          <= cdp_pkg::FLOOR_RST;
			bytes_q.load_cap <= cdp_pkg::LOADCAP_RST;
			bytes_q.out0     <= cdp_pkg::OUT0_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cdp_pkg::CFG_XTAL:    xtal_q <= cfg_wdata[25:0];
				cdp_pkg::CFG_CORR:    corr_q <= cfg_wdata;
				cdp_pkg::CFG_FLOOR:   floor_q <= cfg_wdata;
				cdp_pkg::CFG_LOADCAP: bytes_q.load_cap <= cfg_wdata[7:0];
				cdp_pkg::CFG_OUT0:    bytes_q.out0 <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	cdp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.xtal_hz        (xtal_q),
		.correction_q30 (corr_q),
		.vco_floor_hz   (floor_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	cdp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	cdp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.bytes    (bytes_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
